@@ hdl/hmac_pkg.sv @@
package hmac_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam int unsigned KeyWords = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [7:0] IpadByte = 8'h36;
  localparam logic [7:0] OpadByte = 8'h5c;
  localparam logic [7:0] PadByte  = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [255:0] init_hash();
    return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  endfunction

endpackage

@@ hdl/hmac_core.sv @@
// SHA-256 compression: one round per cycle on a shared round datapath,
// message schedule held in a 16-word sliding window.
module hmac_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] h_in,
  input  logic [511:0] blk,
  output logic         done,
  output logic [255:0] h_out
);
  import hmac_pkg::*;

  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [255:0] h_base;
  logic [5:0]  rnd;
  logic        busy;
  logic        add_pending;

  logic [31:0] t1, t2, s0w, s1w, w_new;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  always_comb begin
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + round_k(rnd) + w[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    s0w = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1w = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + w[9] + s0w + s1w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      add_pending <= 1'b0;
      done <= 1'b0;
      rnd <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd <= '0;
        h_base <= h_in;
        {a, b, c, d, e, f, g, h} <= h_in;
        for (int i = 0; i < 16; i++) w[i] <= blk[511 - 32*i -: 32];
      end else if (busy) begin
        {a, b, c, d, e, f, g, h} <= {t1 + t2, a, b, c, d + t1, e, f, g};
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= w_new;
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          add_pending <= 1'b1;
        end
      end else if (add_pending) begin
        add_pending <= 1'b0;
        done <= 1'b1;
        h_out <= {h_base[255:224] + a, h_base[223:192] + b, h_base[191:160] + c,
                  h_base[159:128] + d, h_base[127:96] + e, h_base[95:64] + f,
                  h_base[63:32] + g, h_base[31:0] + h};
      end
    end
  end
endmodule

@@ hdl/hmac_sha256_stream.sv @@
// HMAC-SHA256 over a byte stream, one request per byte. The key is latched
// when a message starts. All compressions share one round unit, one round per
// clock. The first request of a message also runs the key-block compression,
// and a byte that completes a 64-byte block runs that block's compression.
// The last request runs the inner padding (one or two compressions) and then
// the outer hash (two). Eight digest words follow, index 0 first. No request is
// taken until the last word has gone.
module hmac_sha256_stream (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  hmac_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output hmac_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [hmac_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [hmac_pkg::CfgDataW-1:0]   cfg_data
);
  import hmac_pkg::*;

  typedef enum logic [3:0] {
    IDLE, KEY_IN, ABSORB, BLK_RUN, PAD1, PAD2, OUT1, OUT2, EMIT
  } state_t;

  state_t       state;
  logic [63:0]  key_reg [KeyWords];
  logic [511:0] key_latch;
  logic [511:0] buf_q;
  logic [255:0] chain, outer;
  logic [5:0]   fill_count;
  logic [63:0]  bit_count;
  logic         in_message;
  logic         last_q;
  logic         extra_blk;
  logic [2:0]   widx;

  logic         core_start, core_done;
  logic [255:0] core_h_in, core_h_out;
  logic [511:0] core_blk;

  logic [511:0] key_flat;
  logic [511:0] ipad_blk, opad_blk, pad_a, pad_b, outer_blk;

  always_comb begin
    for (int i = 0; i < KeyWords; i++) key_flat[511 - 64*i -: 64] = key_reg[i];
    for (int i = 0; i < 64; i++) begin
      ipad_blk[511 - 8*i -: 8] = key_latch[511 - 8*i -: 8] ^ IpadByte;
      opad_blk[511 - 8*i -: 8] = key_latch[511 - 8*i -: 8] ^ OpadByte;
    end
    // pad_a: buffer with 0x80 after fill bytes, length if it fits
    // pad_b: zero block with length, used when padding spills over
    for (int i = 0; i < 64; i++) begin
      if (i < fill_count) pad_a[511 - 8*i -: 8] = buf_q[511 - 8*i -: 8];
      else if (i == fill_count) pad_a[511 - 8*i -: 8] = PadByte;
      else pad_a[511 - 8*i -: 8] = 8'h00;
    end
    if (!extra_blk) pad_a[63:0] = bit_count;
    pad_b = {448'd0, bit_count};
    outer_blk = {chain, PadByte, 184'd0, 64'd768};
  end

  assign in_stall  = (state != IDLE);
  assign out_valid = (state == EMIT);
  assign out_data.digest_word = outer[255 - 32*widx -: 32];
  assign out_data.word_index  = widx;
  assign out_data.last_word   = (widx == 3'd7);

  hmac_core u_core (
    .clk   (clk),
    .rst   (rst),
    .start (core_start),
    .h_in  (core_h_in),
    .blk   (core_blk),
    .done  (core_done),
    .h_out (core_h_out)
  );

  logic core_go;
  logic buf_present_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      in_message <= 1'b0;
      fill_count <= '0;
      bit_count <= '0;
      core_start <= 1'b0;
      widx <= '0;
      last_q <= 1'b0;
      extra_blk <= 1'b0;
      core_go <= 1'b0;
      for (int i = 0; i < KeyWords; i++) key_reg[i] <= '0;
      key_latch <= '0;
    end else begin
      core_start <= 1'b0;
      if (cfg_we) key_reg[cfg_index] <= cfg_data;
      case (state)
        IDLE: begin
          if (in_valid && (in_data.byte_present || in_data.last_byte)) begin
            last_q <= in_data.last_byte;
            // fill_count is zero whenever no message is open
            if (in_data.byte_present) buf_q[511 - 8*fill_count -: 8] <= in_data.msg_byte;
            if (!in_message) begin
              key_latch <= key_flat;
              in_message <= 1'b1;
              fill_count <= '0;
              bit_count <= 64'd512;
              state <= KEY_IN;
              core_go <= 1'b1;
            end else state <= ABSORB;
          end
        end
        KEY_IN: begin
          if (core_go) begin
            core_go <= 1'b0;
            core_start <= 1'b1;
            core_h_in <= init_hash();
            core_blk <= ipad_blk;
          end else if (core_done) begin
            chain <= core_h_out;
            state <= ABSORB;
          end
        end
        ABSORB: begin
          // present byte already stored at fill_count
          if (buf_present_q) begin
            fill_count <= fill_count + 6'd1;
            bit_count <= bit_count + 64'd8;
          end
          if (buf_present_q && fill_count == 6'd63) begin
            state <= BLK_RUN;
            core_start <= 1'b1;
            core_h_in <= chain;
            core_blk <= buf_q;
          end else if (last_q) state <= PAD1;
          else state <= IDLE;
          extra_blk <= ({1'b0, fill_count} + (buf_present_q ? 7'd1 : 7'd0)) >= 7'd56;
        end
        BLK_RUN: begin
          if (core_done) begin
            chain <= core_h_out;
            state <= last_q ? PAD1 : IDLE;
            extra_blk <= 1'b0;
          end
        end
        PAD1: begin
          if (!core_go) begin
            core_go <= 1'b1;
            core_start <= 1'b1;
            core_h_in <= chain;
            core_blk <= pad_a;
          end else if (core_done) begin
            chain <= core_h_out;
            core_go <= 1'b0;
            if (extra_blk) state <= PAD2;
            else state <= OUT1;
          end
        end
        PAD2: begin
          if (!core_go) begin
            core_go <= 1'b1;
            core_start <= 1'b1;
            core_h_in <= chain;
            core_blk <= pad_b;
          end else if (core_done) begin
            chain <= core_h_out;
            core_go <= 1'b0;
            state <= OUT1;
          end
        end
        OUT1: begin
          if (!core_go) begin
            core_go <= 1'b1;
            core_start <= 1'b1;
            core_h_in <= init_hash();
            core_blk <= opad_blk;
          end else if (core_done) begin
            outer <= core_h_out;
            core_go <= 1'b0;
            state <= OUT2;
          end
        end
        OUT2: begin
          if (!core_go) begin
            core_go <= 1'b1;
            core_start <= 1'b1;
            core_h_in <= outer;
            core_blk <= outer_blk;
          end else if (core_done) begin
            outer <= core_h_out;
            core_go <= 1'b0;
            fill_count <= '0;
            in_message <= 1'b0;
            widx <= '0;
            state <= EMIT;
          end
        end
        EMIT: begin
          if (!out_stall) begin
            widx <= widx + 3'd1;
            if (widx == 3'd7) state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == IDLE && in_valid) buf_present_q <= in_data.byte_present;
  end
endmodule

@@ hdl/hmac_sha256_stream_chk.sv @@
module hmac_sha256_stream_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input hmac_pkg::out_item_t out_data
);
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken while digest pending");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled digest word changed");
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_word |=>
      out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest word skipped");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last word flag wrong");
endmodule

bind hmac_sha256_stream hmac_sha256_stream_chk u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
